>>> hw/rtl/pcdd_pkg.sv
// ----------------------------------------------------------------------------
// pcdd_pkg
// Shared field widths, command codes and register indexes of the per-channel
// delay dedisperser.
// ----------------------------------------------------------------------------
package pcdd_pkg;

  localparam int CMD_W      = 1;
  localparam int CHAN_FW    = 8;
  localparam int DELAY_W    = 8;
  localparam int SAMPLE_W   = 8;
  localparam int POL_FW     = 2;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POLS     = 1'b1;

  localparam logic [CFG_W-1:0] CHANNELS_RESET = 9'd256;
  localparam logic [2:0]       POLS_RESET     = 3'd1;

endpackage

>>> hw/rtl/pcdd_delay_table.sv
// ----------------------------------------------------------------------------
// pcdd_delay_table
// Per-channel delay memory with registered read and a zeroing sweep after
// reset.
// ----------------------------------------------------------------------------
module pcdd_delay_table #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [pcdd_pkg::DELAY_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [pcdd_pkg::DELAY_W-1:0] rd_data,
  output logic                        busy
);
  import pcdd_pkg::*;

  logic [DELAY_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0]  clr_addr;

  // The sweep writes one zero per cycle until every entry has been cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (32'(clr_addr) == 32'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/pcdd_sample_store.sv
// ----------------------------------------------------------------------------
// pcdd_sample_store
// Ring of past time steps: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pcdd_sample_store #(
  parameter int DEPTH  = 262144,
  parameter int ADDR_W = 18
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [pcdd_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [pcdd_pkg::SAMPLE_W-1:0] rd_data
);
  import pcdd_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  // Read data holds whenever no read is issued, so a stalled stage keeps it.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/per_channel_delay_dedisperser_top.sv
// ----------------------------------------------------------------------------
// per_channel_delay_dedisperser_top
// Path: a sample item passes stage one, stage two and the output register.
// Throughput: one item per cycle unless item_stall is high, set by one delay
// table read and one store read plus write per sample.
// Reset: the delay table is swept to zero over MAX_CHANNELS cycles, during
// which item_stall is high; the registers return to 256 channels, 1 pol.
// ----------------------------------------------------------------------------
module per_channel_delay_dedisperser_top #(
  parameter int MAX_CHANNELS = 256,
  parameter int MAX_POLS     = 4,
  parameter int MAX_DELAY    = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_write,
  input  logic [pcdd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcdd_pkg::CFG_W-1:0]     cfg_data,
  // Input item channel.
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [pcdd_pkg::CMD_W-1:0]     cmd,
  input  logic [pcdd_pkg::CHAN_FW-1:0]   channel,
  input  logic [pcdd_pkg::DELAY_W-1:0]   delay,
  input  logic [pcdd_pkg::SAMPLE_W-1:0]  sample,
  // Result item channel.
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [pcdd_pkg::SAMPLE_W-1:0]  delayed_sample,
  output logic                          filled,
  output logic [pcdd_pkg::CHAN_FW-1:0]   out_channel,
  output logic [pcdd_pkg::POL_FW-1:0]    out_pol,
  output logic                          last_of_spectrum
);
  import pcdd_pkg::*;

  // Index widths. The store is addressed as {time slot, polarisation,
  // channel}, so each lane of a time step sits at a power-of-two stride.
  localparam int CH_W        = $clog2(MAX_CHANNELS);
  localparam int POL_W       = (MAX_POLS > 1) ? $clog2(MAX_POLS) : 1;
  localparam int SLOT_W      = $clog2(MAX_DELAY);
  localparam int STEP_W      = $clog2(MAX_DELAY + 1);
  localparam int LANE_W      = POL_W + CH_W;
  localparam int STORE_AW    = SLOT_W + LANE_W;
  localparam int STORE_DEPTH = MAX_DELAY << LANE_W;

  // How the second stage forms its byte.
  typedef enum logic [1:0] {
    MODE_FWD,
    MODE_PAD,
    MODE_STORE
  } mode_t;

  // Configuration registers.
  logic [CFG_W-1:0] channels_used;
  logic [2:0]       pols_used;

  // Stream position of the next sample item.
  logic [CH_W-1:0]   chan_pos, chan_pos_next;
  logic [POL_W-1:0]  pol_pos, pol_pos_next;
  logic [SLOT_W-1:0] time_slot, time_slot_next;
  logic [STEP_W-1:0] steps_seen, steps_seen_next;

  // Stage one: delay table read data arrives here.
  logic                s1_valid;
  logic [CH_W-1:0]     s1_ch;
  logic [POL_W-1:0]    s1_pol;
  logic [SLOT_W-1:0]   s1_slot;
  logic [STEP_W-1:0]   s1_steps;
  logic                s1_last;
  logic [SAMPLE_W-1:0] s1_sample;

  // Stage two: sample store read data arrives here.
  logic                s2_valid;
  mode_t               s2_mode;
  logic [CH_W-1:0]     s2_ch;
  logic [POL_W-1:0]    s2_pol;
  logic                s2_last;
  logic [SAMPLE_W-1:0] s2_sample;

  logic                accept;
  logic                is_sample;
  logic                s1_adv;
  logic                s2_adv;
  logic                out_free;
  logic                tbl_busy;
  logic                tbl_wr_en;
  logic [CH_W-1:0]     tbl_wr_addr;
  logic [DELAY_W-1:0]  tbl_rd_data;
  logic [31:0]         chan_in32;
  logic [31:0]         last_ch;
  logic [31:0]         last_pol;
  logic                chan_end;
  logic                pol_end;

  logic [31:0]         d32;
  logic [31:0]         slot32;
  logic [31:0]         rd_slot32;
  logic [SLOT_W-1:0]   rd_slot;
  mode_t               s1_mode;
  logic [STORE_AW-1:0] st_wr_addr;
  logic [STORE_AW-1:0] st_rd_addr;
  logic [SAMPLE_W-1:0] st_rd_data;

  // --------------------------------------------------------------------------
  // Handshake. Each stage moves on when the one after it is empty or moving,
  // so a result held in the output register does not stop new items from
  // filling the two stages in front of it.
  // --------------------------------------------------------------------------
  assign out_free   = !result_valid || !result_stall;
  assign s2_adv     = s2_valid && out_free;
  assign s1_adv     = s1_valid && (!s2_valid || s2_adv);
  assign item_stall = tbl_busy || (s1_valid && !s1_adv);
  assign accept     = item_valid && !item_stall;
  assign is_sample  = (cmd == CMD_SAMPLE);

  // --------------------------------------------------------------------------
  // Delay loads. A channel index beyond the table is dropped.
  // --------------------------------------------------------------------------
  assign chan_in32   = 32'(channel);
  assign tbl_wr_addr = chan_in32[CH_W-1:0];
  assign tbl_wr_en   = accept && (cmd == CMD_LOAD) && (chan_in32 < 32'(MAX_CHANNELS));

  pcdd_delay_table #(
    .DEPTH  (MAX_CHANNELS),
    .ADDR_W (CH_W)
  ) u_delay_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (delay),
    .rd_en   (accept && is_sample),
    .rd_addr (chan_pos),
    .rd_data (tbl_rd_data),
    .busy    (tbl_busy)
  );

  // --------------------------------------------------------------------------
  // Stream position. A register value of zero counts as one, and anything
  // above the maximum counts as the maximum.
  // --------------------------------------------------------------------------
  always_comb begin
    if (channels_used == '0) begin
      last_ch = '0;
    end else if (32'(channels_used) > 32'(MAX_CHANNELS)) begin
      last_ch = 32'(MAX_CHANNELS - 1);
    end else begin
      last_ch = 32'(channels_used) - 32'd1;
    end
    if (pols_used == '0) begin
      last_pol = '0;
    end else if (32'(pols_used) > 32'(MAX_POLS)) begin
      last_pol = 32'(MAX_POLS - 1);
    end else begin
      last_pol = 32'(pols_used) - 32'd1;
    end
  end

  assign chan_end = (32'(chan_pos) >= last_ch);
  assign pol_end  = (32'(pol_pos) >= last_pol);

  always_comb begin
    chan_pos_next   = chan_pos + CH_W'(1);
    pol_pos_next    = pol_pos;
    time_slot_next  = time_slot;
    steps_seen_next = steps_seen;
    if (chan_end) begin
      chan_pos_next = '0;
      if (!pol_end) begin
        pol_pos_next = pol_pos + POL_W'(1);
      end else begin
        // A whole time step is complete: move the ring on by one slot.
        pol_pos_next = '0;
        if (32'(time_slot) + 32'd1 >= 32'(MAX_DELAY)) begin
          time_slot_next = '0;
        end else begin
          time_slot_next = time_slot + SLOT_W'(1);
        end
        if (32'(steps_seen) < 32'(MAX_DELAY)) begin
          steps_seen_next = steps_seen + STEP_W'(1);
        end
      end
    end
  end

  // Configuration and position registers. A register write restarts the
  // stream, so zero padding begins again; delays and stored bytes stay.
  always_ff @(posedge clk) begin
    if (rst) begin
      channels_used <= CHANNELS_RESET;
      pols_used     <= POLS_RESET;
      chan_pos      <= '0;
      pol_pos       <= '0;
      time_slot     <= '0;
      steps_seen    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHANNELS: channels_used <= cfg_data;
        REG_POLS:     pols_used     <= cfg_data[2:0];
        default:      ;
      endcase
      chan_pos   <= '0;
      pol_pos    <= '0;
      time_slot  <= '0;
      steps_seen <= '0;
    end else if (accept && is_sample) begin
      chan_pos   <= chan_pos_next;
      pol_pos    <= pol_pos_next;
      time_slot  <= time_slot_next;
      steps_seen <= steps_seen_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage one: a sample item with its position snapshot. The delay is held
  // in the table's read register until the item moves on.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= is_sample;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_sample) begin
      s1_ch     <= chan_pos;
      s1_pol    <= pol_pos;
      s1_slot   <= time_slot;
      s1_steps  <= steps_seen;
      s1_last   <= chan_end && pol_end;
      s1_sample <= sample;
    end
  end

  // Delays beyond the ring saturate at its last slot. The slot to read lies
  // d steps behind the current one, wrapping round the ring.
  always_comb begin
    d32 = 32'(tbl_rd_data);
    if (d32 > 32'(MAX_DELAY - 1)) begin
      d32 = 32'(MAX_DELAY - 1);
    end
    slot32 = 32'(s1_slot);
    if (slot32 >= d32) begin
      rd_slot32 = slot32 - d32;
    end else begin
      rd_slot32 = slot32 + 32'(MAX_DELAY) - d32;
    end
    rd_slot = rd_slot32[SLOT_W-1:0];
    if (d32 == 32'd0) begin
      s1_mode = MODE_FWD;
    end else if (d32 > 32'(s1_steps)) begin
      s1_mode = MODE_PAD;
    end else begin
      s1_mode = MODE_STORE;
    end
  end

  // The read slot lies at least one step behind the write slot for a nonzero
  // delay, so then the write and read of one cycle never meet; a zero delay
  // forwards instead. Earlier writes land before later reads, as items pass in order.
  assign st_wr_addr = {s1_slot, s1_pol, s1_ch};
  assign st_rd_addr = {rd_slot, s1_pol, s1_ch};

  pcdd_sample_store #(
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (STORE_AW)
  ) u_sample_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (st_wr_addr),
    .wr_data (s1_sample),
    .rd_en   (s1_adv),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // --------------------------------------------------------------------------
  // Stage two.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_mode   <= s1_mode;
      s2_ch     <= s1_ch;
      s2_pol    <= s1_pol;
      s2_last   <= s1_last;
      s2_sample <= s1_sample;
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_channel      <= CHAN_FW'(32'(s2_ch));
      out_pol          <= POL_FW'(32'(s2_pol));
      last_of_spectrum <= s2_last;
      case (s2_mode)
        MODE_FWD: begin
          delayed_sample <= s2_sample;
          filled         <= 1'b1;
        end
        MODE_STORE: begin
          delayed_sample <= st_rd_data;
          filled         <= 1'b1;
        end
        default: begin
          delayed_sample <= '0;
          filled         <= 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // No item may enter while the delay table is still being cleared.
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    tbl_busy |-> item_stall)
    else $error("item accepted during delay table clear");

  // A held second stage must keep its store read data. Padding and forwarded
  // items may hold a never-written byte, so the comparison is exact.
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_adv) |=> (s2_valid && (st_rd_data === $past(st_rd_data))))
    else $error("stalled store read data changed");

  // Padding always carries a zero byte.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !filled) |-> (delayed_sample == '0))
    else $error("padding result is not zero");

endmodule

>>> verif/pcdd_checker.sv
// ----------------------------------------------------------------------------
// pcdd_checker
// Watches the configuration port and both item channels of the per-channel
// delay dedisperser, predicts each result and compares it with what arrives.
// ----------------------------------------------------------------------------
module pcdd_checker #(
  parameter int MAX_CHANNELS = 256,
  parameter int MAX_POLS     = 4,
  parameter int MAX_DELAY    = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pcdd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcdd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  logic [pcdd_pkg::CMD_W-1:0]      cmd,
  input  logic [pcdd_pkg::CHAN_FW-1:0]    channel,
  input  logic [pcdd_pkg::DELAY_W-1:0]    delay,
  input  logic [pcdd_pkg::SAMPLE_W-1:0]   sample,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  logic [pcdd_pkg::SAMPLE_W-1:0]   delayed_sample,
  input  logic                            filled,
  input  logic [pcdd_pkg::CHAN_FW-1:0]    out_channel,
  input  logic [pcdd_pkg::POL_FW-1:0]     out_pol,
  input  logic                            last_of_spectrum,
  output int                              failures,
  output int                              checked,
  output int                              awaited
);
  import pcdd_pkg::*;

  localparam int LANES        = MAX_CHANNELS * MAX_POLS;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                filled;
    logic [CHAN_FW-1:0]  chan;
    logic [POL_FW-1:0]   pol;
    logic                last;
  } spectrum_byte_t;

  spectrum_byte_t       pending_bytes [$];
  logic [CFG_W-1:0]     chans_reg;
  logic [2:0]           pols_reg;
  logic [DELAY_W-1:0]   chan_delay [MAX_CHANNELS];
  bit   [SAMPLE_W-1:0]  history [LANES*MAX_DELAY];
  int                   chan_pos;
  int                   pol_pos;
  int                   ring_slot;
  int                   steps_done;

  // A count of zero behaves as one, and anything above the maximum as the maximum.
  function automatic int clamp_count(input int v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  task automatic restart_stream;
    chan_pos   = 0;
    pol_pos    = 0;
    ring_slot  = 0;
    steps_done = 0;
  endtask

  // Works out the byte answered for one sample and moves the stream position on.
  function automatic spectrum_byte_t dedisperse(input logic [SAMPLE_W-1:0] fresh);
    int             nch;
    int             npol;
    int             lag;
    int             lane;
    int             src;
    spectrum_byte_t r;
    nch  = clamp_count(chans_reg, MAX_CHANNELS);
    npol = clamp_count(pols_reg, MAX_POLS);
    lag  = chan_delay[chan_pos];
    if (lag > MAX_DELAY - 1) lag = MAX_DELAY - 1;
    lane = pol_pos * MAX_CHANNELS + chan_pos;
    if (lag == 0) begin
      r.value  = fresh;
      r.filled = 1'b1;
    end else if (lag > steps_done) begin
      r.value  = '0;
      r.filled = 1'b0;
    end else begin
      src      = (ring_slot >= lag) ? ring_slot - lag : ring_slot + MAX_DELAY - lag;
      r.value  = history[src*LANES + lane];
      r.filled = 1'b1;
    end
    history[ring_slot*LANES + lane] = fresh;
    r.chan = chan_pos[CHAN_FW-1:0];
    r.pol  = pol_pos[POL_FW-1:0];
    r.last = (chan_pos + 1 >= nch) && (pol_pos + 1 >= npol);
    if (chan_pos + 1 < nch) begin
      chan_pos++;
    end else begin
      chan_pos = 0;
      if (pol_pos + 1 < npol) begin
        pol_pos++;
      end else begin
        pol_pos   = 0;
        ring_slot = (ring_slot + 1 >= MAX_DELAY) ? 0 : ring_slot + 1;
        if (steps_done < MAX_DELAY) steps_done++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    spectrum_byte_t want;
    spectrum_byte_t got;
    if (rst) begin
      chans_reg = CHANNELS_RESET;
      pols_reg  = POLS_RESET;
      for (int i = 0; i < MAX_CHANNELS; i++) chan_delay[i] = '0;
      restart_stream();
      pending_bytes.delete();
      failures = 0;
      checked  = 0;
    end else begin
      // Results are taken first so that one arriving with nothing queued is
      // never matched against an item accepted on the same edge.
      if (result_valid && !result_stall) begin
        got.value  = delayed_sample;
        got.filled = filled;
        got.chan   = out_channel;
        got.pol    = out_pol;
        got.last   = last_of_spectrum;
        if (pending_bytes.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("unexpected result: byte %02h filled %0b ch %0d pol %0d last %0b",
                     got.value, got.filled, got.chan, got.pol, got.last);
        end else begin
          want = pending_bytes.pop_front();
          checked++;
          if (got !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("mismatch on result %0d: expected byte %02h filled %0b ch %0d pol %0d last %0b, got byte %02h filled %0b ch %0d pol %0d last %0b",
                       checked, want.value, want.filled, want.chan, want.pol, want.last,
                       got.value, got.filled, got.chan, got.pol, got.last);
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_CHANNELS) chans_reg = cfg_data;
        else if (cfg_index == REG_POLS) pols_reg = cfg_data[2:0];
        restart_stream();
      end
      if (item_valid && !item_stall) begin
        if (cmd == CMD_LOAD) begin
          if (channel < MAX_CHANNELS) chan_delay[channel] = delay;
        end else begin
          pending_bytes.push_back(dedisperse(sample));
        end
      end
    end
    awaited = pending_bytes.size();
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives delay loads, register settings and filterbank samples into the
// per-channel delay dedisperser under random idling on both sides, while a
// checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb;
  import pcdd_pkg::*;

  // The run ends in failure if it ever gets this far; a correct run with the
  // longest gaps and stalls on every item stays well below it.
  localparam int CYCLE_LIMIT = 400000;
  // A sample item's result passes stage one, stage two and the output register,
  // so this many idle cycles are enough for any item still inside the block.
  localparam int SETTLE      = 8;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;
  logic                   item_valid;
  logic                   item_stall;
  logic [CMD_W-1:0]       cmd;
  logic [CHAN_FW-1:0]     channel;
  logic [DELAY_W-1:0]     delay;
  logic [SAMPLE_W-1:0]    sample;
  logic                   result_valid;
  logic                   result_stall;
  logic [SAMPLE_W-1:0]    delayed_sample;
  logic                   filled;
  logic [CHAN_FW-1:0]     out_channel;
  logic [POL_FW-1:0]      out_pol;
  logic                   last_of_spectrum;

  int failures;
  int checked;
  int awaited;
  int loads_sent     = 0;
  int samples_sent   = 0;
  int settings_used  = 0;
  int results_taken  = 0;
  int cycles         = 0;
  bit quiet_send     = 1'b0;
  bit quiet_recv     = 1'b0;

  per_channel_delay_dedisperser_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .cmd              (cmd),
    .channel          (channel),
    .delay            (delay),
    .sample           (sample),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .delayed_sample   (delayed_sample),
    .filled           (filled),
    .out_channel      (out_channel),
    .out_pol          (out_pol),
    .last_of_spectrum (last_of_spectrum)
  );

  pcdd_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .cmd              (cmd),
    .channel          (channel),
    .delay            (delay),
    .sample           (sample),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .delayed_sample   (delayed_sample),
    .filled           (filled),
    .out_channel      (out_channel),
    .out_pol          (out_pol),
    .last_of_spectrum (last_of_spectrum),
    .failures         (failures),
    .checked          (checked),
    .awaited          (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d results outstanding", cycles, awaited);
      $display("status: fail");
      $finish;
    end
  end

  // Result side. Before each item the receiver holds stall for a random
  // number of cycles, then lowers it until an item has been taken. Now and
  // then it switches to a quiet spell in which it never stalls at all.
  initial begin : result_drain
    int hold;
    result_stall = 1'b0;
    forever begin
      hold = quiet_recv ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid === 1'b1 && !result_stall));
      results_taken++;
      if (results_taken % 48 == 0) quiet_recv = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  // Offers one item after a random gap and returns at the falling edge after
  // it has been accepted. It is always entered at a falling edge, and it
  // only lowers valid when a gap is drawn, so a back-to-back item keeps
  // valid high without a glitch.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [CHAN_FW-1:0] ch,
                           input logic [DELAY_W-1:0] d, input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    channel    <= ch;
    delay      <= d;
    sample     <= s;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    if (c == CMD_LOAD) loads_sent++;
    else samples_sent++;
  endtask

  // Sends one sample item with random values in its unused fields.
  task automatic send_random_sample;
    send_item(CMD_SAMPLE, CHAN_FW'($urandom_range(0, 255)), DELAY_W'($urandom_range(0, 255)),
              SAMPLE_W'($urandom_range(0, 255)));
  endtask

  // Stops offering items and waits until every expected result has come
  // out. Delay loads give no result, so SETTLE more idle cycles are allowed for
  // one that may still be on its way through the block.
  task automatic drain_block;
    item_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes both registers on consecutive edges; either write restarts the
  // stream inside the block.
  task automatic write_regs(input logic [CFG_W-1:0] chans, input logic [CFG_W-1:0] pols);
    cfg_write <= 1'b1;
    cfg_index <= REG_CHANNELS;
    cfg_data  <= chans;
    @(negedge clk);
    cfg_index <= REG_POLS;
    cfg_data  <= pols;
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Mostly short delays so that real data comes back soon, with the odd
  // value at the top of the range and the odd fully random one.
  function automatic logic [DELAY_W-1:0] pick_delay;
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return DELAY_W'($urandom_range(0, 3));
    if (r < 15) return DELAY_W'($urandom_range(0, 15));
    if (r < 18) return DELAY_W'($urandom_range(254, 255));
    return DELAY_W'($urandom_range(0, 255));
  endfunction

  // One register setting followed by a stream of mostly samples. Delay
  // loads are scattered through it, aimed mostly at channels in use so that
  // delays change mid-stream. A hold point, if given, makes the sender wait
  // for every outstanding result before carrying on.
  task automatic run_phase(input logic [CFG_W-1:0] chans, input logic [CFG_W-1:0] pols,
                           input int span, input int count, input int hold_at);
    logic [CHAN_FW-1:0] ch;
    drain_block();
    write_regs(chans, pols);
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) quiet_send = ($urandom_range(0, 3) == 0);
      if (k == hold_at) drain_block();
      if ($urandom_range(0, 99) < 8) begin
        if ($urandom_range(0, 9) < 7) ch = CHAN_FW'($urandom_range(0, span - 1));
        else ch = CHAN_FW'($urandom_range(0, 255));
        send_item(CMD_LOAD, ch, pick_delay(), SAMPLE_W'($urandom_range(0, 255)));
      end else begin
        send_random_sample();
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = REG_CHANNELS;
    cfg_data   = '0;
    item_valid = 1'b0;
    cmd        = CMD_LOAD;
    channel    = '0;
    delay      = '0;
    sample     = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed part. The first loads also wait out the delay table sweep
    // after reset, since the block stalls its input until that is done.
    // The sample field of a load is set to a busy pattern to show that it
    // is ignored; channel 255 is the top of the table.
    send_item(CMD_LOAD, 8'd0,   8'd0,   8'hFF);
    send_item(CMD_LOAD, 8'd1,   8'd1,   8'h00);
    send_item(CMD_LOAD, 8'd2,   8'd255, 8'hFF);
    send_item(CMD_LOAD, 8'd3,   8'd2,   8'h00);
    send_item(CMD_LOAD, 8'd255, 8'd255, 8'hAA);
    send_item(CMD_LOAD, 8'd128, 8'd7,   8'h55);
    drain_block();
    // Four channels by two polarisations: eight samples per time step. The
    // zero delay channel forwards its input, the others pad until enough
    // steps have passed, and channel and delay are ignored on samples.
    write_regs(9'd4, 9'd2);
    send_item(CMD_SAMPLE, 8'hFF, 8'hFF, 8'h00);
    send_item(CMD_SAMPLE, 8'h00, 8'h00, 8'hFF);
    send_item(CMD_SAMPLE, 8'hFF, 8'h00, 8'h55);
    send_item(CMD_SAMPLE, 8'h00, 8'hFF, 8'hAA);
    for (int i = 0; i < 12; i++)
      send_random_sample();
    // A load between two time steps takes effect for the next sample of
    // that channel without restarting the stream.
    send_item(CMD_LOAD, 8'd3, 8'd0, 8'hFF);
    for (int i = 0; i < 4; i++)
      send_random_sample();

    // Random part. A register value of zero acts as one and values above
    // the maximum act as the maximum. The long single channel phase runs to
    // about the depth of the sample ring, so the largest delays can read real
    // data once the ring has wrapped; the full sized settings get only a few
    // items.
    run_phase(9'd0,   9'd2, 1,   560, 280);
    run_phase(9'd3,   9'd0, 3,   120, -1);
    run_phase(9'd5,   9'd3, 5,   120, -1);
    run_phase(9'd2,   9'd7, 2,   100, -1);
    run_phase(9'd511, 9'd4, 256, 60,  -1);
    run_phase(9'd256, 9'd1, 256, 40,  -1);
    run_phase(9'd1,   9'd1, 1,   40,  -1);
    drain_block();

    $display("sent %0d delay loads and %0d samples over %0d register settings",
             loads_sent, samples_sent, settings_used);
    $display("compared %0d results, %0d failures", checked, failures);
    if (failures == 0 && awaited == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
